// ===== hw/rtl/tmk_pkg.sv =====
package tmk_pkg;

    // default build values
    localparam int MAX_ORDER  = 8;
    localparam int FRAC_BITS  = 24;
    localparam int WORD_WIDTH = 32;

    // tilt values are fixed at Q1.30 in a 32-bit word
    localparam int TILT_W    = 32;
    localparam int TILT_FRAC = 30;
    localparam logic signed [TILT_W-1:0] TILT_ONE = TILT_W'(1) << TILT_FRAC;

    localparam int ORDER_W  = 4;
    localparam int STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_SAT     = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        REG_POLE_ORDER = 3'd0,
        REG_KICK       = 3'd1,
        REG_TILT_COS   = 3'd2,
        REG_TILT_SIN   = 3'd3,
        REG_OFFSET_H   = 3'd4,
        REG_OFFSET_V   = 3'd5
    } t_reg_idx;

endpackage

// ===== hw/rtl/tmk_div.sv =====
// Restoring divider, one quotient bit per stage.
// Quotient >= 2^Q_W is reported as o_ovf.
module tmk_div #(
    parameter int NUM_W = 57,
    parameter int DEN_W = 34,
    parameter int Q_W   = 32
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quo,
    output logic             o_ovf
);

    localparam int HI_W = NUM_W - Q_W;
    localparam int CW   = ((HI_W > DEN_W) ? HI_W : DEN_W) + 1;

    logic [DEN_W-1:0] r_rem [0:Q_W];
    logic [Q_W-1:0]   r_low [0:Q_W];
    logic [Q_W-1:0]   r_q   [0:Q_W];
    logic [DEN_W-1:0] r_den [0:Q_W];
    logic             r_ovf [0:Q_W];

    logic [CW-1:0] hi_ext;
    logic [CW-1:0] den_ext;

    assign hi_ext  = CW'(i_num[NUM_W-1:Q_W]);
    assign den_ext = CW'(i_den);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0] <= (hi_ext >= den_ext);
            r_rem[0] <= (hi_ext >= den_ext) ? '0 : DEN_W'(hi_ext);
            r_low[0] <= i_num[Q_W-1:0];
            r_q[0]   <= '0;
            r_den[0] <= i_den;
        end
    end

    for (genvar i = 1; i <= Q_W; i++) begin : g_step
        logic [DEN_W:0] trial;
        logic           take;

        assign trial = {r_rem[i-1], r_low[i-1][Q_W-1]};
        assign take  = (trial >= {1'b0, r_den[i-1]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i] <= take ? DEN_W'(trial - {1'b0, r_den[i-1]}) : DEN_W'(trial);
                r_low[i] <= r_low[i-1] << 1;
                r_q[i]   <= {r_q[i-1][Q_W-2:0], take};
                r_den[i] <= r_den[i-1];
                r_ovf[i] <= r_ovf[i-1];
            end
        end
    end

    assign o_quo = r_q[Q_W];
    assign o_ovf = r_ovf[Q_W];

endmodule

// ===== hw/rtl/thin_multipole_kick_core.sv =====
// Channel  | valid    | stall    | payload
// ---------+----------+----------+---------------------------------------------------
// in       | i_valid  | o_stall  | i_pos_*, i_mom_*_in, i_momentum_deviation
// out      | o_valid  | i_stall  | o_mom_horizontal_out, o_mom_vertical_out, o_kick_status
// config   | psel/penable/pwrite, pready tied high, paddr/pwdata/prdata
//
// One particle per clock while o_stall is low; the pipeline depth is set by the three stages
// per complex multiply step and the one-bit-per-stage divider.
// Reset is synchronous; it clears valid bits and the config registers (cosine = 1.0).
// The pipeline advances whenever the output skid register is empty; a stalled output
// parks one transfer in the skid, and o_stall is that skid's valid bit.
// Config must only be written while no particle is in flight.
module thin_multipole_kick_core #(
    parameter int MAX_ORDER  = tmk_pkg::MAX_ORDER,
    parameter int FRAC_BITS  = tmk_pkg::FRAC_BITS,
    parameter int WORD_WIDTH = tmk_pkg::WORD_WIDTH,
    localparam int PDW = (WORD_WIDTH > 32) ? 64 : 32,
    localparam int PAW = ((WORD_WIDTH > 32) ? 3 : 2) + 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [PAW-1:0]                paddr,
    input  logic [PDW-1:0]                pwdata,
    output logic [PDW-1:0]                prdata,
    output logic                          pready,
    // particle in
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [WORD_WIDTH-1:0]  i_pos_horizontal,
    input  logic signed [WORD_WIDTH-1:0]  i_pos_vertical,
    input  logic signed [WORD_WIDTH-1:0]  i_mom_horizontal_in,
    input  logic signed [WORD_WIDTH-1:0]  i_mom_vertical_in,
    input  logic signed [WORD_WIDTH-1:0]  i_momentum_deviation,
    // kicked particle out
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [WORD_WIDTH-1:0]  o_mom_horizontal_out,
    output logic signed [WORD_WIDTH-1:0]  o_mom_vertical_out,
    output logic [tmk_pkg::STATUS_W-1:0]  o_kick_status
);

    localparam int W   = WORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int TW  = tmk_pkg::TILT_W;
    localparam int TF  = tmk_pkg::TILT_FRAC;
    localparam int OW  = tmk_pkg::ORDER_W;
    localparam int PW  = W + ((W > TW) ? W : TW);   // product width, covers both kinds
    localparam int DNW = ((W > F) ? W : F) + 2;     // 1 + deviation
    localparam int NW  = W + F + 1;                 // divider numerator
    localparam int AST = PAW - 3;

    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    typedef logic signed [W-1:0]  t_word;
    typedef logic signed [TW-1:0] t_tilt;
    typedef logic signed [PW-1:0] t_prod;

    typedef struct packed {
        logic  f;
        t_word val;
    } t_rs;

    // travels alongside the math
    typedef struct packed {
        t_word            px;
        t_word            py;
        logic [DNW-1:0]   dn;
        logic             inv;
        logic             f;
    } t_side;

    // ------------------------------------------------------------------
    // arithmetic helpers
    // ------------------------------------------------------------------
    function automatic t_prod mul_wt(input t_word a, input t_tilt b);
        logic signed [W+TW-1:0] p;
        p = a * b;
        return t_prod'(p);
    endfunction

    function automatic t_prod mul_ww(input t_word a, input t_word b);
        logic signed [2*W-1:0] p;
        p = a * b;
        return t_prod'(p);
    endfunction

    // round half away from zero, drop sh fraction bits, saturate to word
    function automatic t_rs rnd_sat(input t_prod p, input int sh);
        logic          neg;
        logic [PW:0]   m;
        logic [PW:0]   lim;
        t_rs           r;
        neg = p[PW-1];
        m   = neg ? ({1'b0, ~p} + 1'b1) : {1'b0, p};
        m   = (m + ((PW+1)'(1) << (sh - 1))) >> sh;
        lim = ((PW+1)'(1) << (W - 1)) - {{PW{1'b0}}, ~neg};
        if (m > lim) begin
            r.f   = 1'b1;
            r.val = neg ? WMIN : WMAX;
        end else begin
            r.f   = 1'b0;
            r.val = neg ? t_word'(~m[W-1:0] + 1'b1) : t_word'(m[W-1:0]);
        end
        return r;
    endfunction

    function automatic t_rs add_sat(input t_word a, input t_word b, input logic sub);
        logic signed [W:0] s;
        t_rs               r;
        s = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
        if (s[W] != s[W-1]) begin
            r.f   = 1'b1;
            r.val = s[W] ? WMIN : WMAX;
        end else begin
            r.f   = 1'b0;
            r.val = s[W-1:0];
        end
        return r;
    endfunction

    // sideband copy with the saturation flag replaced
    function automatic t_side with_flag(input t_side s, input logic f);
        t_side r;
        r   = s;
        r.f = f;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // config registers
    // ------------------------------------------------------------------
    logic [OW-1:0] r_pole_order;
    t_word         r_kick;
    t_tilt         r_tilt_cos;
    t_tilt         r_tilt_sin;
    t_word         r_offset_h;
    t_word         r_offset_v;
    logic [2:0]    reg_idx;

    assign reg_idx = paddr[PAW-1:AST];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pole_order <= '0;
            r_kick       <= '0;
            r_tilt_cos   <= tmk_pkg::TILT_ONE;
            r_tilt_sin   <= '0;
            r_offset_h   <= '0;
            r_offset_v   <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                tmk_pkg::REG_POLE_ORDER: r_pole_order <= pwdata[OW-1:0];
                tmk_pkg::REG_KICK:       r_kick       <= pwdata[W-1:0];
                tmk_pkg::REG_TILT_COS:   r_tilt_cos   <= pwdata[TW-1:0];
                tmk_pkg::REG_TILT_SIN:   r_tilt_sin   <= pwdata[TW-1:0];
                tmk_pkg::REG_OFFSET_H:   r_offset_h   <= pwdata[W-1:0];
                tmk_pkg::REG_OFFSET_V:   r_offset_v   <= pwdata[W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            tmk_pkg::REG_POLE_ORDER: prdata = PDW'(r_pole_order);
            tmk_pkg::REG_KICK:       prdata = PDW'($unsigned(r_kick));
            tmk_pkg::REG_TILT_COS:   prdata = PDW'($unsigned(r_tilt_cos));
            tmk_pkg::REG_TILT_SIN:   prdata = PDW'($unsigned(r_tilt_sin));
            tmk_pkg::REG_OFFSET_H:   prdata = PDW'($unsigned(r_offset_h));
            tmk_pkg::REG_OFFSET_V:   prdata = PDW'($unsigned(r_offset_v));
            default:                 prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline enable: everything moves while the skid is empty
    // ------------------------------------------------------------------
    logic r_skv;
    logic en;

    assign en      = !r_skv;
    assign o_stall = r_skv;

    // ------------------------------------------------------------------
    // s0: offset subtract, 1 + deviation
    // ------------------------------------------------------------------
    logic signed [DNW-1:0] dn_s;
    t_rs                   dx_rs;
    t_rs                   dy_rs;

    assign dn_s  = DNW'(i_momentum_deviation) + (DNW'(1) << F);
    assign dx_rs = add_sat(i_pos_horizontal, r_offset_h, 1'b1);
    assign dy_rs = add_sat(i_pos_vertical, r_offset_v, 1'b1);

    logic  r_v0;
    t_side r_sd0;
    t_word r_dx;
    t_word r_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else if (en)  r_v0 <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx      <= dx_rs.val;
            r_dy      <= dy_rs.val;
            r_sd0.px  <= i_mom_horizontal_in;
            r_sd0.py  <= i_mom_vertical_in;
            r_sd0.dn  <= dn_s;
            r_sd0.inv <= dn_s[DNW-1] || (dn_s == '0);
            r_sd0.f   <= dx_rs.f || dy_rs.f;
        end
    end

    // ------------------------------------------------------------------
    // s1..s3: rotate into the element frame
    // ------------------------------------------------------------------
    logic  r_v1, r_v2, r_v3;
    t_side r_sd1, r_sd2, r_sd3;
    t_prod r_p1 [4];
    t_rs   r_r2 [4];
    t_word r_u3, r_w3;
    t_rs   u_rs, w_rs;

    assign u_rs = add_sat(r_r2[0].val, r_r2[1].val, 1'b0);
    assign w_rs = add_sat(r_r2[2].val, r_r2[3].val, 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd1   <= r_sd0;
            r_p1[0] <= mul_wt(r_dx, r_tilt_cos);
            r_p1[1] <= mul_wt(r_dy, r_tilt_sin);
            r_p1[2] <= mul_wt(r_dy, r_tilt_cos);
            r_p1[3] <= mul_wt(r_dx, r_tilt_sin);

            r_sd2 <= r_sd1;
            for (int i = 0; i < 4; i++) r_r2[i] <= rnd_sat(r_p1[i], TF);

            r_sd3 <= with_flag(r_sd2, r_sd2.f || r_r2[0].f || r_r2[1].f || r_r2[2].f
                               || r_r2[3].f || u_rs.f || w_rs.f);
            r_u3  <= u_rs.val;
            r_w3  <= w_rs.val;
        end
    end

    // ------------------------------------------------------------------
    // power chain: one complex multiply per order step, bypassed past order
    // ------------------------------------------------------------------
    logic  ch_vld [0:MAX_ORDER];
    t_side ch_sd  [0:MAX_ORDER];
    t_word ch_re  [0:MAX_ORDER];
    t_word ch_im  [0:MAX_ORDER];
    t_word ch_u   [0:MAX_ORDER];
    t_word ch_w   [0:MAX_ORDER];

    assign ch_vld[0] = r_v3;
    assign ch_sd[0]  = r_sd3;
    assign ch_re[0]  = r_u3;
    assign ch_im[0]  = r_w3;
    assign ch_u[0]   = r_u3;
    assign ch_w[0]   = r_w3;

    for (genvar k = 0; k < MAX_ORDER; k++) begin : g_pow
        logic  r_mv, r_rv, r_av;
        t_side r_msd, r_rsd, r_asd;
        t_word r_mre, r_mim, r_mu, r_mw;
        t_word r_rre, r_rim, r_ru, r_rw;
        t_word r_are, r_aim, r_au, r_aw;
        t_prod r_mp [4];
        t_rs   r_rr [4];
        t_rs   nr_rs, ni_rs;
        logic  act;

        assign act   = (int'(r_pole_order) > k);
        assign nr_rs = add_sat(r_rr[0].val, r_rr[1].val, 1'b1);
        assign ni_rs = add_sat(r_rr[2].val, r_rr[3].val, 1'b0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mv <= 1'b0;
                r_rv <= 1'b0;
                r_av <= 1'b0;
            end else if (en) begin
                r_mv <= ch_vld[k];
                r_rv <= r_mv;
                r_av <= r_rv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_msd   <= ch_sd[k];
                r_mre   <= ch_re[k];
                r_mim   <= ch_im[k];
                r_mu    <= ch_u[k];
                r_mw    <= ch_w[k];
                r_mp[0] <= mul_ww(ch_re[k], ch_u[k]);
                r_mp[1] <= mul_ww(ch_im[k], ch_w[k]);
                r_mp[2] <= mul_ww(ch_re[k], ch_w[k]);
                r_mp[3] <= mul_ww(ch_im[k], ch_u[k]);

                r_rsd <= r_msd;
                r_rre <= r_mre;
                r_rim <= r_mim;
                r_ru  <= r_mu;
                r_rw  <= r_mw;
                for (int i = 0; i < 4; i++) r_rr[i] <= rnd_sat(r_mp[i], F);

                r_asd <= act ? with_flag(r_rsd, r_rsd.f || r_rr[0].f || r_rr[1].f
                                         || r_rr[2].f || r_rr[3].f || nr_rs.f || ni_rs.f)
                             : r_rsd;
                r_au  <= r_ru;
                r_aw  <= r_rw;
                if (act) begin
                    r_are <= nr_rs.val;
                    r_aim <= ni_rs.val;
                end else begin
                    r_are <= r_rre;
                    r_aim <= r_rim;
                end
            end
        end

        assign ch_vld[k+1] = r_av;
        assign ch_sd[k+1]  = r_asd;
        assign ch_re[k+1]  = r_are;
        assign ch_im[k+1]  = r_aim;
        assign ch_u[k+1]   = r_au;
        assign ch_w[k+1]   = r_aw;
    end

    // ------------------------------------------------------------------
    // rotate back to lab frame, then strength multiply
    // ------------------------------------------------------------------
    logic  r_tv1, r_tv2, r_tv3, r_kv1, r_kv2;
    t_side r_tsd1, r_tsd2, r_tsd3, r_ksd1, r_ksd2;
    t_prod r_tp1 [4];
    t_rs   r_tr2 [4];
    t_word r_a3, r_b3;
    t_prod r_kp1 [2];
    t_rs   r_kr2 [2];
    t_rs   a_rs, b_rs;

    assign a_rs = add_sat(r_tr2[0].val, r_tr2[1].val, 1'b0);
    assign b_rs = add_sat(r_tr2[2].val, r_tr2[3].val, 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv1 <= 1'b0;
            r_tv2 <= 1'b0;
            r_tv3 <= 1'b0;
            r_kv1 <= 1'b0;
            r_kv2 <= 1'b0;
        end else if (en) begin
            r_tv1 <= ch_vld[MAX_ORDER];
            r_tv2 <= r_tv1;
            r_tv3 <= r_tv2;
            r_kv1 <= r_tv3;
            r_kv2 <= r_kv1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tsd1   <= ch_sd[MAX_ORDER];
            r_tp1[0] <= mul_wt(ch_re[MAX_ORDER], r_tilt_cos);
            r_tp1[1] <= mul_wt(ch_im[MAX_ORDER], r_tilt_sin);
            r_tp1[2] <= mul_wt(ch_re[MAX_ORDER], r_tilt_sin);
            r_tp1[3] <= mul_wt(ch_im[MAX_ORDER], r_tilt_cos);

            r_tsd2 <= r_tsd1;
            for (int i = 0; i < 4; i++) r_tr2[i] <= rnd_sat(r_tp1[i], TF);

            r_tsd3 <= with_flag(r_tsd2, r_tsd2.f || r_tr2[0].f || r_tr2[1].f || r_tr2[2].f
                                || r_tr2[3].f || a_rs.f || b_rs.f);
            r_a3   <= a_rs.val;
            r_b3   <= b_rs.val;

            r_ksd1   <= r_tsd3;
            r_kp1[0] <= mul_ww(r_kick, r_a3);
            r_kp1[1] <= mul_ww(r_kick, r_b3);

            r_ksd2   <= r_ksd1;
            r_kr2[0] <= rnd_sat(r_kp1[0], F);
            r_kr2[1] <= rnd_sat(r_kp1[1], F);
        end
    end

    // ------------------------------------------------------------------
    // divide by 1 + deviation (rounded), magnitudes through the divider
    // ------------------------------------------------------------------
    logic [W-1:0]  kx_mag, ky_mag;
    logic          r_dv0;
    t_side         r_dsd0;
    logic          r_nx0, r_ny0;
    logic [NW-1:0] r_numx, r_numy;

    assign kx_mag = r_kr2[0].val[W-1] ? (~r_kr2[0].val + 1'b1) : r_kr2[0].val;
    assign ky_mag = r_kr2[1].val[W-1] ? (~r_kr2[1].val + 1'b1) : r_kr2[1].val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv0 <= 1'b0;
        else if (en)  r_dv0 <= r_kv2;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dsd0 <= with_flag(r_ksd2, r_ksd2.f || r_kr2[0].f || r_kr2[1].f);
            r_nx0  <= r_kr2[0].val[W-1];
            r_ny0  <= r_kr2[1].val[W-1];
            r_numx <= {1'b0, kx_mag, {F{1'b0}}} + NW'(r_ksd2.dn >> 1);
            r_numy <= {1'b0, ky_mag, {F{1'b0}}} + NW'(r_ksd2.dn >> 1);
        end
    end

    logic [W-1:0] qx, qy;
    logic         ovx, ovy;

    tmk_div #(.NUM_W(NW), .DEN_W(DNW), .Q_W(W)) u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_numx),
        .i_den (r_dsd0.dn),
        .o_quo (qx),
        .o_ovf (ovx)
    );

    tmk_div #(.NUM_W(NW), .DEN_W(DNW), .Q_W(W)) u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_numy),
        .i_den (r_dsd0.dn),
        .o_quo (qy),
        .o_ovf (ovy)
    );

    // sideband delay matching the divider depth
    logic  r_dvl [0:W];
    t_side r_dsd [0:W];
    logic  r_dnx [0:W];
    logic  r_dny [0:W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= W; i++) r_dvl[i] <= 1'b0;
        end else if (en) begin
            r_dvl[0] <= r_dv0;
            for (int i = 1; i <= W; i++) r_dvl[i] <= r_dvl[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dsd[0] <= r_dsd0;
            r_dnx[0] <= r_nx0;
            r_dny[0] <= r_ny0;
            for (int i = 1; i <= W; i++) begin
                r_dsd[i] <= r_dsd[i-1];
                r_dnx[i] <= r_dnx[i-1];
                r_dny[i] <= r_dny[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // e1: sign and saturate quotient; e2: add to momenta, status
    // ------------------------------------------------------------------
    logic [W-1:0] limx, limy;
    logic         satx, saty;
    logic         r_ev1;
    t_side        r_esd1;
    t_word        r_qx1, r_qy1;

    assign limx = r_dnx[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    assign limy = r_dny[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    assign satx = ovx || (qx > limx);
    assign saty = ovy || (qy > limy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ev1 <= 1'b0;
        else if (en)  r_ev1 <= r_dvl[W];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_esd1 <= with_flag(r_dsd[W], r_dsd[W].f || satx || saty);
            if (satx)         r_qx1 <= r_dnx[W] ? WMIN : WMAX;
            else if (r_dnx[W]) r_qx1 <= ~qx + 1'b1;
            else              r_qx1 <= qx;
            if (saty)         r_qy1 <= r_dny[W] ? WMIN : WMAX;
            else if (r_dny[W]) r_qy1 <= ~qy + 1'b1;
            else              r_qy1 <= qy;
        end
    end

    t_rs              pxo_rs, pyo_rs;
    logic             r_tv;
    t_word            r_tpx, r_tpy;
    tmk_pkg::t_status r_tst;

    assign pxo_rs = add_sat(r_esd1.px, r_qx1, 1'b0);
    assign pyo_rs = add_sat(r_esd1.py, r_qy1, 1'b0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_tv <= 1'b0;
        else if (en)  r_tv <= r_ev1;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_esd1.inv) begin
                // bad deviation: momenta pass untouched
                r_tpx <= r_esd1.px;
                r_tpy <= r_esd1.py;
                r_tst <= tmk_pkg::ST_INVALID;
            end else begin
                r_tpx <= pxo_rs.val;
                r_tpy <= pyo_rs.val;
                r_tst <= (r_esd1.f || pxo_rs.f || pyo_rs.f) ? tmk_pkg::ST_SAT
                                                             : tmk_pkg::ST_OK;
            end
        end
    end

    // ------------------------------------------------------------------
    // output register plus one skid entry
    // ------------------------------------------------------------------
    logic             r_ov;
    logic             out_free;
    t_word            r_opx, r_opy, r_spx, r_spy;
    tmk_pkg::t_status r_ost, r_sst;

    assign out_free = !r_ov || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_skv <= 1'b0;
        end else if (out_free) begin
            if (r_skv) begin
                r_ov  <= 1'b1;
                r_skv <= 1'b0;
            end else begin
                r_ov  <= r_tv;
            end
        end else if (r_tv && en) begin
            r_skv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skv) begin
                r_opx <= r_spx;
                r_opy <= r_spy;
                r_ost <= r_sst;
            end else begin
                r_opx <= r_tpx;
                r_opy <= r_tpy;
                r_ost <= r_tst;
            end
        end else if (en) begin
            r_spx <= r_tpx;
            r_spy <= r_tpy;
            r_sst <= r_tst;
        end
    end

    assign o_valid              = r_ov;
    assign o_mom_horizontal_out = r_opx;
    assign o_mom_vertical_out   = r_opy;
    assign o_kick_status        = r_ost;

endmodule

// ===== hw/rtl/tmk_checker.sv =====
module tmk_checker #(
    parameter int WORD_WIDTH = 32
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic signed [WORD_WIDTH-1:0] o_mom_horizontal_out
);

    // stalled transfer stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output valid dropped under stall");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_mom_horizontal_out))
        else $error("output payload changed under stall");

    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

    // skid only holds data while the output register is full
    a_skid_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output");

    a_skid_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stall without output stall");

endmodule

bind thin_multipole_kick_core tmk_checker #(.WORD_WIDTH(WORD_WIDTH)) u_tmk_checker (.*);
